// File: rtl/arrive_steering_accel_unit_assert.svh
// Assertion macros for the arrive steering block checkers.
// No dependencies; the user supplies i_clk and i_rst_n in scope.
`ifndef ARRIVE_STEERING_ACCEL_UNIT_ASSERT_SVH
`define ARRIVE_STEERING_ACCEL_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define ASA_CHECK(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("asa: check failed");

// implication after a fixed number of cycles
`define ASA_CHECK_DLY(lbl, ante, dly, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##dly (cons)) \
        else $error("asa: latency check failed");

`endif

// File: rtl/asa_pkg.sv
// Shared types and constants of the arrive steering block.
// No dependencies.
package asa_pkg;

    localparam int unsigned ROOT_W = 32;   // square root result bits
    localparam int unsigned QUOT_W = 31;   // divider quotient bits
    localparam int unsigned DIVR_W = 32;   // divider divisor bits
    // 13 single stages, two root units, three dividers
    localparam int unsigned LATENCY = 13 + 2 * ROOT_W + 3 * QUOT_W;

    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_TARGET_RADIUS = 3'd0;
    localparam t_reg_idx REG_SLOW_RADIUS   = 3'd1;
    localparam t_reg_idx REG_INV_TIME      = 3'd2;
    localparam t_reg_idx REG_MAX_SPEED     = 3'd3;
    localparam t_reg_idx REG_MAX_ACCEL     = 3'd4;

    typedef logic [2:0][31:0] t_vec3;

    typedef struct packed {
        logic [2:0] dir_neg;
        t_vec3      dir_mag;
        t_vec3      vel;
    } t_tag_d1;

    typedef struct packed {
        logic        arrived;
        logic        use_max;
        logic        dist_zero;
        logic [31:0] dist_len;
        logic [2:0]  dir_neg;
        t_vec3       dir_mag;
        t_vec3       vel;
    } t_tag_s1;

    typedef struct packed {
        logic       arrived;
        logic       dist_zero;
        logic [2:0] dir_neg;
        t_vec3      vel;
    } t_tag_s2;

    typedef struct packed {
        logic       arrived;
        logic [2:0] acc_neg;
        t_vec3      acc_mag;
    } t_tag_s3;

    typedef struct packed {
        logic       arrived;
        logic       clip;
        logic [2:0] acc_neg;
        t_vec3      acc_mag;
    } t_tag_s4;

endpackage

// File: rtl/arrive_steering_accel_unit.sv
// Arrive steering acceleration: a fully pipelined path from start to o_done,
// one transfer accepted every cycle, busy never rises.
// The path is two 32-stage square root pipes and three 31-stage
// divider pipes plus 13 single stages of add, multiply and select.
// Reset (synchronous, i_rst_n low) clears every valid bit and loads the
// register defaults; items in flight are dropped.
module arrive_steering_accel_unit
    import asa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_target_x,
    input  logic [31:0] i_target_y,
    input  logic [31:0] i_target_z,
    input  logic [31:0] i_agent_x,
    input  logic [31:0] i_agent_y,
    input  logic [31:0] i_agent_z,
    input  logic [31:0] i_vel_x,
    input  logic [31:0] i_vel_y,
    input  logic [31:0] i_vel_z,
    // result strobe
    output logic        o_done,
    output logic [31:0] o_accel_x,
    output logic [31:0] o_accel_y,
    output logic [31:0] o_accel_z,
    output logic        o_arrived,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [30:0] r_target_radius, r_slow_radius, r_inv_time, r_max_speed, r_max_accel;
    t_reg_idx    w_idx;

    assign w_idx  = paddr[4:2];
    assign pready = 1'b1;
    assign busy   = 1'b0;   // fully pipelined, never refuses a transfer

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_radius <= 31'd131072;
            r_slow_radius   <= 31'd655360;
            r_inv_time      <= 31'd655360;
            r_max_speed     <= 31'd327680;
            r_max_accel     <= 31'd327680;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_TARGET_RADIUS: r_target_radius <= pwdata[30:0];
                REG_SLOW_RADIUS:   r_slow_radius   <= pwdata[30:0];
                REG_INV_TIME:      r_inv_time      <= pwdata[30:0];
                REG_MAX_SPEED:     r_max_speed     <= pwdata[30:0];
                REG_MAX_ACCEL:     r_max_accel     <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_TARGET_RADIUS: prdata = {1'b0, r_target_radius};
            REG_SLOW_RADIUS:   prdata = {1'b0, r_slow_radius};
            REG_INV_TIME:      prdata = {1'b0, r_inv_time};
            REG_MAX_SPEED:     prdata = {1'b0, r_max_speed};
            REG_MAX_ACCEL:     prdata = {1'b0, r_max_accel};
            default:           prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage A: direction = sat(target - agent), split into sign/magnitude
    // ------------------------------------------------------------------
    t_vec3 w_tgt, w_agt, w_vel;
    assign w_tgt = {i_target_z, i_target_y, i_target_x};
    assign w_agt = {i_agent_z, i_agent_y, i_agent_x};
    assign w_vel = {i_vel_z, i_vel_y, i_vel_x};

    t_tag_d1 n_a_tag;
    always_comb begin
        logic [32:0] d;
        logic [31:0] dir;
        for (int i = 0; i < 3; i++) begin
            d = {w_tgt[i][31], w_tgt[i]} - {w_agt[i][31], w_agt[i]};
            // overflow when the two top bits disagree
            if (d[32] != d[31]) begin
                dir = d[32] ? 32'h8000_0000 : 32'h7fff_ffff;
            end else begin
                dir = d[31:0];
            end
            n_a_tag.dir_neg[i] = dir[31];
            n_a_tag.dir_mag[i] = dir[31] ? (~dir + 32'd1) : dir;
        end
        n_a_tag.vel = w_vel;
    end

    logic    r_a_vld, r_b_vld, r_c_vld;
    t_tag_d1 r_a_tag, r_b_tag, r_c_tag;
    logic [2:0][63:0] r_b_sq;
    logic [63:0]      r_c_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !busy;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    // Stage B squares, stage C sum (3 * 2^62 fits 64 bits)
    always_ff @(posedge i_clk) begin
        r_a_tag <= n_a_tag;
        r_b_tag <= r_a_tag;
        r_c_tag <= r_b_tag;
        for (int i = 0; i < 3; i++) begin
            r_b_sq[i] <= r_a_tag.dir_mag[i] * r_a_tag.dir_mag[i];
        end
        r_c_sum <= r_b_sq[0] + r_b_sq[1] + r_b_sq[2];
    end

    // ------------------------------------------------------------------
    // Distance
    // ------------------------------------------------------------------
    logic        s1_vld;
    logic [31:0] s1_dist;
    t_tag_d1     s1_tag;

    asa_isqrt #(.OW(ROOT_W), .TW($bits(t_tag_d1))) u_dist (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_c_vld),
        .i_rad  (r_c_sum),
        .i_tag  (r_c_tag),
        .o_vld  (s1_vld),
        .o_root (s1_dist),
        .o_tag  (s1_tag)
    );

    // Stage D: arrive test, slow-down product max_speed * dist
    logic            r_d_vld;
    t_tag_s1         r_d_tag;
    logic [0:0][62:0] r_d_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_tag.arrived   <= s1_dist < {1'b0, r_target_radius};
        r_d_tag.use_max   <= (r_slow_radius == 31'd0) || (s1_dist > {1'b0, r_slow_radius});
        r_d_tag.dist_zero <= (s1_dist == 32'd0);
        r_d_tag.dist_len  <= s1_dist;
        r_d_tag.dir_neg   <= s1_tag.dir_neg;
        r_d_tag.dir_mag   <= s1_tag.dir_mag;
        r_d_tag.vel       <= s1_tag.vel;
        r_d_prod[0]       <= r_max_speed * s1_dist;
    end

    // speed = max_speed * dist / slow_radius
    logic             q1_vld;
    logic [0:0][30:0] q1_quo;
    t_tag_s1          q1_tag;

    asa_div #(.NL(1), .VW(DIVR_W), .QW(QUOT_W), .TW($bits(t_tag_s1))) u_speed (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_d_vld),
        .i_dvd  (r_d_prod),
        .i_dvs  ({1'b0, r_slow_radius}),
        .i_tag  (r_d_tag),
        .o_vld  (q1_vld),
        .o_quo  (q1_quo),
        .o_tag  (q1_tag)
    );

    // Stage E: pick speed, scale each direction magnitude by it
    logic             r_e_vld;
    t_tag_s2          r_e_tag;
    logic [31:0]      r_e_dist;
    logic [2:0][62:0] r_e_prod;
    logic [30:0]      w_speed;

    assign w_speed = q1_tag.use_max ? r_max_speed : q1_quo[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= q1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_tag.arrived   <= q1_tag.arrived;
        r_e_tag.dist_zero <= q1_tag.dist_zero;
        r_e_tag.dir_neg   <= q1_tag.dir_neg;
        r_e_tag.vel       <= q1_tag.vel;
        r_e_dist          <= q1_tag.dist_len;
        for (int i = 0; i < 3; i++) begin
            r_e_prod[i] <= q1_tag.dir_mag[i] * w_speed;
        end
    end

    // desired magnitude = |dir| * speed / dist, at most speed since |dir| <= dist
    logic             q2_vld;
    logic [2:0][30:0] q2_quo;
    t_tag_s2          q2_tag;

    asa_div #(.NL(3), .VW(DIVR_W), .QW(QUOT_W), .TW($bits(t_tag_s2))) u_desired (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_e_vld),
        .i_dvd  (r_e_prod),
        .i_dvs  (r_e_dist),
        .i_tag  (r_e_tag),
        .o_vld  (q2_vld),
        .o_quo  (q2_quo),
        .o_tag  (q2_tag)
    );

    // ------------------------------------------------------------------
    // Stages F..I: diff = desired - vel, * inv_time >> 16, saturate
    // ------------------------------------------------------------------
    logic             r_f_vld, r_g_vld, r_h_vld, r_i_vld;
    logic             r_f_arr, r_g_arr, r_h_arr;
    logic [2:0][33:0] r_f_diff;
    logic [2:0]       r_g_neg, r_h_neg;
    t_vec3            r_g_mag;
    logic [2:0][62:0] r_h_prod;
    t_tag_s3          r_i_tag;
    logic [2:0][33:0] n_f_diff;

    always_comb begin
        logic [33:0] des;
        for (int i = 0; i < 3; i++) begin
            if (q2_tag.dist_zero) begin
                des = 34'd0;
            end else if (q2_tag.dir_neg[i]) begin
                des = 34'd0 - {3'b000, q2_quo[i]};
            end else begin
                des = {3'b000, q2_quo[i]};
            end
            n_f_diff[i] = des - {{2{q2_tag.vel[i][31]}}, q2_tag.vel[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_h_vld <= 1'b0;
            r_i_vld <= 1'b0;
        end else begin
            r_f_vld <= q2_vld;
            r_g_vld <= r_f_vld;
            r_h_vld <= r_g_vld;
            r_i_vld <= r_h_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [46:0] p;
        logic [31:0] lim;
        r_f_arr  <= q2_tag.arrived;
        r_f_diff <= n_f_diff;
        r_g_arr  <= r_f_arr;
        r_h_arr  <= r_g_arr;
        r_i_tag.arrived <= r_h_arr;
        r_h_neg  <= r_g_neg;
        for (int i = 0; i < 3; i++) begin
            // |diff| < 2^32
            r_g_neg[i] <= r_f_diff[i][33];
            r_g_mag[i] <= r_f_diff[i][33] ? 32'(34'd0 - r_f_diff[i]) : r_f_diff[i][31:0];
            r_h_prod[i] <= r_g_mag[i] * r_inv_time;
            // saturate magnitude: 2^31 for negative, 2^31-1 for positive
            p   = r_h_prod[i][62:16];
            lim = r_h_neg[i] ? 32'h8000_0000 : 32'h7fff_ffff;
            r_i_tag.acc_neg[i] <= r_h_neg[i];
            r_i_tag.acc_mag[i] <= (p > {15'd0, lim}) ? lim : p[31:0];
        end
    end

    // Stages J, K: squares and sum of acceleration
    logic             r_j_vld, r_k_vld;
    t_tag_s3          r_j_tag, r_k_tag;
    logic [2:0][63:0] r_j_sq;
    logic [63:0]      r_k_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_vld <= 1'b0;
            r_k_vld <= 1'b0;
        end else begin
            r_j_vld <= r_i_vld;
            r_k_vld <= r_j_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j_tag <= r_i_tag;
        r_k_tag <= r_j_tag;
        for (int i = 0; i < 3; i++) begin
            r_j_sq[i] <= r_i_tag.acc_mag[i] * r_i_tag.acc_mag[i];
        end
        r_k_sum <= r_j_sq[0] + r_j_sq[1] + r_j_sq[2];
    end

    logic        s2_vld;
    logic [31:0] s2_mag;
    t_tag_s3     s2_tag;

    asa_isqrt #(.OW(ROOT_W), .TW($bits(t_tag_s3))) u_amag (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_k_vld),
        .i_rad  (r_k_sum),
        .i_tag  (r_k_tag),
        .o_vld  (s2_vld),
        .o_root (s2_mag),
        .o_tag  (s2_tag)
    );

    // Stage L: clip test and |acc| * max_accel
    logic             r_l_vld;
    t_tag_s4          r_l_tag;
    logic [31:0]      r_l_mag;
    logic [2:0][62:0] r_l_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_vld <= 1'b0;
        end else begin
            r_l_vld <= s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l_tag.arrived <= s2_tag.arrived;
        r_l_tag.clip    <= s2_mag > {1'b0, r_max_accel};
        r_l_tag.acc_neg <= s2_tag.acc_neg;
        r_l_tag.acc_mag <= s2_tag.acc_mag;
        r_l_mag         <= s2_mag;
        for (int i = 0; i < 3; i++) begin
            r_l_prod[i] <= s2_tag.acc_mag[i] * r_max_accel;
        end
    end

    // quotient is only used when clipping, then it stays at most max_accel
    logic             q3_vld;
    logic [2:0][30:0] q3_quo;
    t_tag_s4          q3_tag;

    asa_div #(.NL(3), .VW(DIVR_W), .QW(QUOT_W), .TW($bits(t_tag_s4))) u_clip (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_l_vld),
        .i_dvd  (r_l_prod),
        .i_dvs  (r_l_mag),
        .i_tag  (r_l_tag),
        .o_vld  (q3_vld),
        .o_quo  (q3_quo),
        .o_tag  (q3_tag)
    );

    // Stage M: restore sign, force zero when arrived
    logic        r_done, r_arrived;
    t_vec3       r_acc;
    t_vec3       n_acc;

    always_comb begin
        logic [31:0] m;
        for (int i = 0; i < 3; i++) begin
            m = q3_tag.clip ? {1'b0, q3_quo[i]} : q3_tag.acc_mag[i];
            if (q3_tag.arrived) begin
                n_acc[i] = 32'd0;
            end else begin
                n_acc[i] = q3_tag.acc_neg[i] ? (~m + 32'd1) : m;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done    <= 1'b0;
            r_arrived <= 1'b0;
        end else begin
            r_done    <= q3_vld;
            r_arrived <= q3_vld && q3_tag.arrived;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_done    = r_done;
    assign o_arrived = r_arrived;
    assign o_accel_x = r_acc[0];
    assign o_accel_y = r_acc[1];
    assign o_accel_z = r_acc[2];

endmodule

// File: rtl/asa_isqrt.sv
// Pipelined floor square root, one result bit per stage, with sideband tag.
// Depends on nothing.
module asa_isqrt #(
    parameter int unsigned OW = 32,
    parameter int unsigned TW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [2*OW-1:0]   i_rad,
    input  logic [TW-1:0]     i_tag,
    output logic              o_vld,
    output logic [OW-1:0]     o_root,
    output logic [TW-1:0]     o_tag
);
    localparam int unsigned RW = OW + 3;

    logic              r_vld  [OW];
    logic [OW-1:0]     r_root [OW];
    logic [TW-1:0]     r_tag  [OW];
    logic [RW-1:0]     r_rem  [OW-1];
    logic [2*OW-1:0]   r_rad  [OW-1];

    for (genvar k = 0; k < OW; k++) begin : g_stage
        logic            p_vld;
        logic [RW-1:0]   p_rem;
        logic [OW-1:0]   p_root;
        logic [2*OW-1:0] p_rad;
        logic [TW-1:0]   p_tag;
        logic [RW-1:0]   w_t;
        logic [RW-1:0]   w_trial;
        logic            w_ge;
        logic [RW-1:0]   n_rem;

        if (k == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = i_rad;
            assign p_tag  = i_tag;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_rad  = r_rad[k-1];
            assign p_tag  = r_tag[k-1];
        end

        assign w_t     = {p_rem[RW-3:0], p_rad[2*OW-1 -: 2]};
        assign w_trial = {1'b0, p_root, 2'b01};
        assign w_ge    = (w_t >= w_trial);
        assign n_rem   = w_ge ? (w_t - w_trial) : w_t;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_root[k] <= {p_root[OW-2:0], w_ge};
            r_tag[k]  <= p_tag;
        end

        if (k < OW - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                r_rem[k] <= n_rem;
                r_rad[k] <= {p_rad[2*OW-3:0], 2'b00};
            end
        end
    end

    assign o_vld  = r_vld[OW-1];
    assign o_root = r_root[OW-1];
    assign o_tag  = r_tag[OW-1];

endmodule

// File: rtl/asa_div.sv
// Pipelined restoring divider, NL lanes over one shared divisor, one
// quotient bit per stage; the dividend must stay below divisor << QW.
module asa_div #(
    parameter int unsigned NL = 3,
    parameter int unsigned VW = 32,
    parameter int unsigned QW = 31,
    parameter int unsigned TW = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  logic [NL-1:0][VW+QW-1:0]     i_dvd,
    input  logic [VW-1:0]                i_dvs,
    input  logic [TW-1:0]                i_tag,
    output logic                         o_vld,
    output logic [NL-1:0][QW-1:0]        o_quo,
    output logic [TW-1:0]                o_tag
);
    logic                   r_vld [QW];
    logic [TW-1:0]          r_tag [QW];
    logic [NL-1:0][QW-1:0]  r_sh  [QW];
    logic [NL-1:0][VW-1:0]  r_rem [QW-1];
    logic [VW-1:0]          r_dvs [QW-1];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic                  p_vld;
        logic [TW-1:0]         p_tag;
        logic [VW-1:0]         p_dvs;
        logic [NL-1:0][VW-1:0] p_rem;
        logic [NL-1:0][QW-1:0] p_sh;
        logic [NL-1:0][VW-1:0] n_rem;
        logic [NL-1:0][QW-1:0] n_sh;

        if (k == 0) begin : g_first
            assign p_vld = i_vld;
            assign p_tag = i_tag;
            assign p_dvs = i_dvs;
            for (genvar l = 0; l < NL; l++) begin : g_ld
                assign p_rem[l] = i_dvd[l][VW+QW-1:QW];
                assign p_sh[l]  = i_dvd[l][QW-1:0];
            end
        end else begin : g_next
            assign p_vld = r_vld[k-1];
            assign p_tag = r_tag[k-1];
            assign p_dvs = r_dvs[k-1];
            assign p_rem = r_rem[k-1];
            assign p_sh  = r_sh[k-1];
        end

        always_comb begin
            logic [VW:0] t;
            logic        ge;
            for (int l = 0; l < NL; l++) begin
                t  = {p_rem[l], p_sh[l][QW-1]};
                ge = (t >= {1'b0, p_dvs});
                n_rem[l] = ge ? VW'(t - {1'b0, p_dvs}) : t[VW-1:0];
                n_sh[l]  = {p_sh[l][QW-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_tag[k] <= p_tag;
            r_sh[k]  <= n_sh;
        end

        if (k < QW - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                r_rem[k] <= n_rem;
                r_dvs[k] <= p_dvs;
            end
        end
    end

    assign o_vld = r_vld[QW-1];
    assign o_quo = r_sh[QW-1];
    assign o_tag = r_tag[QW-1];

endmodule

// File: rtl/asa_checker.sv
// Port-level checks for arrive_steering_accel_unit, bound to the top level.
// Depends on asa_pkg and arrive_steering_accel_unit_assert.svh.
`include "arrive_steering_accel_unit_assert.svh"

module asa_checker
    import asa_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [31:0] o_accel_x,
    input logic [31:0] o_accel_y,
    input logic [31:0] o_accel_z,
    input logic        o_arrived,
    input logic        pready
);

    // an arrived result carries no acceleration
    `ASA_CHECK(a_arrived_zero, o_done && o_arrived, o_accel_x == 32'd0 && o_accel_y == 32'd0 && o_accel_z == 32'd0)

    // the flag only shows with a result
    `ASA_CHECK(a_arrived_strobe, !o_done, !o_arrived)

    // every accepted transfer comes out after the fixed latency
    `ASA_CHECK_DLY(a_latency, start && !busy, LATENCY, o_done)

    // register port never waits
    `ASA_CHECK(a_pready, 1'b1, pready)

endmodule

bind arrive_steering_accel_unit asa_checker u_asa_checker (.*);

// File: tb/sv/tb_top.sv
// Testbench for arrive_steering_accel_unit: directed and random steering items,
// checked against a fixed-point arrive predictor. Depends on asa_pkg and the RTL.
module tb_top;
    import asa_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_target_x = '0, i_target_y = '0, i_target_z = '0;
    logic [31:0] i_agent_x = '0, i_agent_y = '0, i_agent_z = '0;
    logic [31:0] i_vel_x = '0, i_vel_y = '0, i_vel_z = '0;
    logic        o_done;
    logic [31:0] o_accel_x, o_accel_y, o_accel_z;
    logic        o_arrived;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // one steering result
    typedef struct packed {
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] az;
        logic        arr;
    } t_steer;

    t_steer      steer_q[$];
    int          err_cnt = 0;
    int          send_idle_pct = 0;

    // local copy of the register file
    longint unsigned arrive_rad, slow_rad, inv_ttt, top_speed, top_accel;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    arrive_steering_accel_unit DUT (.*);

    // ---------------- predictor ----------------
    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned floor_root(longint unsigned s);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned vec_len(longint a, longint b, longint c);
        longint unsigned ma, mb, mc;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        mc = c < 0 ? -c : c;
        return floor_root(ma * ma + mb * mb + mc * mc);
    endfunction

    // v * mul / div, truncated toward zero
    function automatic longint mul_div(longint v, longint unsigned mul,
                                       longint unsigned dv);
        longint unsigned m, r;
        m = v < 0 ? -v : v;
        r = m * mul / dv;
        return v < 0 ? -longint'(r) : longint'(r);
    endfunction

    function automatic t_steer arrive_accel(logic [8:0][31:0] f);
        longint          dir [3];
        longint          acc [3];
        longint          want;
        longint unsigned d_len, spd, amag;
        t_steer          r;
        for (int i = 0; i < 3; i++)
            dir[i] = clamp32(longint'($signed(f[i])) - longint'($signed(f[3+i])));
        d_len = vec_len(dir[0], dir[1], dir[2]);
        if (d_len < arrive_rad) begin
            r = '{ax: '0, ay: '0, az: '0, arr: 1'b1};
            return r;
        end
        if (slow_rad == 0 || d_len > slow_rad) spd = top_speed;
        else spd = top_speed * d_len / slow_rad;
        for (int i = 0; i < 3; i++) begin
            want = (d_len == 0) ? 0 : mul_div(dir[i], spd, d_len);
            acc[i] = clamp32(mul_div(want - longint'($signed(f[6+i])), inv_ttt, 65536));
        end
        amag = vec_len(acc[0], acc[1], acc[2]);
        if (amag > top_accel)
            for (int i = 0; i < 3; i++) acc[i] = mul_div(acc[i], top_accel, amag);
        r.ax = acc[0][31:0];
        r.ay = acc[1][31:0];
        r.az = acc[2][31:0];
        r.arr = 1'b0;
        return r;
    endfunction

    // ---------------- drivers ----------------
    // f order: target xyz, agent xyz, velocity xyz
    // start stays high after the transfer; the next idle cycle or drain drops it
    task automatic send_item(logic [8:0][31:0] f);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        {i_vel_z, i_vel_y, i_vel_x, i_agent_z, i_agent_y, i_agent_x,
         i_target_z, i_target_y, i_target_x} <= f;
        start <= 1'b1;
        steer_q.push_back(arrive_accel(f));
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic drain();
        int n;
        n = 0;
        start <= 1'b0;
        while (steer_q.size() != 0 && n < 100000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (LATENCY + 20) @(posedge i_clk);
    endtask

    // access phase runs straight into the next setup phase; set_regs closes the bus
    task automatic reg_write(t_reg_idx idx, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 5'(idx) << 2; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_TARGET_RADIUS: arrive_rad = val[30:0];
            REG_SLOW_RADIUS:   slow_rad   = val[30:0];
            REG_INV_TIME:      inv_ttt    = val[30:0];
            REG_MAX_SPEED:     top_speed  = val[30:0];
            default:           top_accel  = val[30:0];
        endcase
    endtask

    task automatic set_regs(logic [31:0] tr, logic [31:0] sr, logic [31:0] it,
                            logic [31:0] ms, logic [31:0] ma);
        drain();
        reg_write(REG_TARGET_RADIUS, tr);
        reg_write(REG_SLOW_RADIUS, sr);
        reg_write(REG_INV_TIME, it);
        reg_write(REG_MAX_SPEED, ms);
        reg_write(REG_MAX_ACCEL, ma);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // mostly modest positions so every branch (arrive, slow, full speed) is hit
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            2, 3:    return 32'($signed($urandom_range(131072)) - 65536);
            default: return 32'($signed($urandom_range(2000000)) - 1000000);
        endcase
    endfunction

    function automatic logic [8:0][31:0] rand_item();
        logic [8:0][31:0] f;
        for (int i = 0; i < 9; i++) f[i] = rand_coord();
        // often place the target close to the agent
        if ($urandom_range(2) == 0)
            for (int i = 0; i < 3; i++)
                f[i] = f[3+i] + 32'($signed($urandom_range(400000)) - 200000);
        return f;
    endfunction

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        t_steer got, exp_r;
        if (i_rst_n && o_done) begin
            got = '{ax: o_accel_x, ay: o_accel_y, az: o_accel_z, arr: o_arrived};
            if (steer_q.size() == 0) begin
                $display("%0t: result with none pending: %h", $time, got);
                err_cnt++;
            end else begin
                exp_r = steer_q.pop_front();
                if (got.ax !== exp_r.ax) begin
                    $display("%0t: accel_x exp %h got %h", $time, exp_r.ax, got.ax);
                    err_cnt++;
                end
                if (got.ay !== exp_r.ay) begin
                    $display("%0t: accel_y exp %h got %h", $time, exp_r.ay, got.ay);
                    err_cnt++;
                end
                if (got.az !== exp_r.az) begin
                    $display("%0t: accel_z exp %h got %h", $time, exp_r.az, got.az);
                    err_cnt++;
                end
                if (got.arr !== exp_r.arr) begin
                    $display("%0t: arrived exp %b got %b", $time, exp_r.arr, got.arr);
                    err_cnt++;
                end
            end
        end
    end

    // ---------------- tests ----------------
    task automatic test_directed();
        logic [8:0][31:0] f;
        f = '0;
        send_item(f);                                 // zero distance, arrived
        f[0] = 32'h0003_0000;
        send_item(f);                                 // inside slow radius
        f[0] = 32'h0064_0000;
        send_item(f);                                 // full speed
        f[6] = 32'h7fffffff; f[7] = 32'h80000000;
        send_item(f);                                 // extreme velocity, clipped
        f = '0;
        f[0] = 32'h7fffffff; f[3] = 32'h80000000;     // saturated direction
        f[1] = 32'h80000000; f[4] = 32'h7fffffff;
        f[2] = 32'hffffffff; f[5] = 32'h00000001;
        send_item(f);
        f = {9{32'hffffffff}};
        send_item(f);
        f = {9{32'h80000000}};
        send_item(f);
        f = {9{32'h7fffffff}};
        send_item(f);
        f = '0; f[8] = 32'hfff0_0000;
        send_item(f);
    endtask

    task automatic test_reg_corners();
        logic [8:0][31:0] f;
        // zero target radius: zero distance is not arrived
        set_regs(32'h0, 32'h000a_0000, 32'h000a_0000, 32'h0005_0000, 32'h0005_0000);
        f = '0; f[6] = 32'h0001_0000;
        send_item(f);
        f[0] = 32'h0000_8000;
        send_item(f);
        // zero slow radius, zero speed and zero accel (upper bit masked)
        set_regs(32'h8000_0000, 32'h0, 32'h7fffffff, 32'h0, 32'h0);
        repeat (4) send_item(rand_item());
        // zero target radius with the rest at maximum; then inverse time and slow radius of one
        set_regs(32'h0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        repeat (6) send_item(rand_item());
        set_regs(32'h0001_0000, 32'h1, 32'h1, 32'h7fffffff, 32'h7fffffff);
        repeat (6) send_item(rand_item());
    endtask

    task automatic test_random(int n);
        for (int k = 0; k < n; k++) begin
            if (k % 150 == 0)
                set_regs($urandom_range(1) ? 32'($urandom_range(400000)) : $urandom,
                         32'($urandom_range(2000000, 1)), 32'($urandom_range(2000000, 1)),
                         32'($urandom_range(1000000)), $urandom_range(1) ?
                         32'($urandom_range(1000000)) : $urandom);
            send_item(rand_item());
        end
    endtask

    initial begin
        arrive_rad = 131072; slow_rad = 655360; inv_ttt = 655360;
        top_speed = 327680; top_accel = 327680;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 34;
        test_directed();
        test_reg_corners();
        test_random(350);
        send_idle_pct = 87;
        test_random(300);
        send_idle_pct = 0;
        test_random(350);
        drain();
        if (err_cnt == 0 && steer_q.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            if (steer_q.size() != 0)
                $display("%0t: %0d results never arrived", $time, steer_q.size());
            $display("tb_top: done, errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_top: done, errors");
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl
rtl/asa_pkg.sv
rtl/asa_isqrt.sv
rtl/asa_div.sv
rtl/arrive_steering_accel_unit.sv
rtl/asa_checker.sv
tb/sv/tb_top.sv
